// ===== rtl/ahtgaq_pkg.sv =====
// ----------------------------------------------------------------------------
// ahtgaq_pkg
// Shared types and constants of the gain-adaptive quantizer.
// ----------------------------------------------------------------------------
package ahtgaq_pkg;

  localparam int SAMPLE_W = 24;
  localparam int MAG_W    = 24;
  localparam int CODE_W   = 16;
  localparam int WID_W    = 5;
  localparam int GSEL_W   = 2;

  localparam logic [GSEL_W-1:0] GAIN_X1   = 2'd0;
  localparam logic [GSEL_W-1:0] GAIN_X2   = 2'd1;
  localparam logic [GSEL_W-1:0] GAIN_X4   = 2'd2;
  localparam logic [GSEL_W-1:0] GAIN_RSVD = 2'd3;

  localparam logic [WID_W-1:0] MIN_MANT = 5'd3;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [CODE_W-1:0] codeword;
    logic [WID_W-1:0]  codeword_width;
    logic              escape_used;
    logic [CODE_W-1:0] escape_code;
    logic [WID_W-1:0]  escape_width;
    logic              neg;
  } code_t;

  localparam int CODE_T_W = $bits(code_t);

endpackage

// ===== rtl/ahtgaq_fifo.sv =====
// ----------------------------------------------------------------------------
// ahtgaq_fifo
// Short register queue between the classifying front and the divider back.
// ----------------------------------------------------------------------------
module ahtgaq_fifo import ahtgaq_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(full && empty))
    else $error("queue full and empty at once");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == CNT_W'($past(count) + 1'b1)))
    else $error("queue count missed a push");

endmodule

// ===== rtl/ahtgaq_front.sv =====
// ----------------------------------------------------------------------------
// ahtgaq_front
// Accepts coefficients, picks the quantizer, forms codes and the division
// operands for the reconstruction.
// ----------------------------------------------------------------------------
module ahtgaq_front import ahtgaq_pkg::*; #(
  parameter int MB = 16,
  parameter int F  = 23
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic [WID_W-1:0]     mantissa_width,
  input  logic [GSEL_W-1:0]    gain_select,
  input  logic                 item_valid,
  output logic                 item_ready,
  output logic                 rec_valid,
  input  logic                 rec_full,
  output code_t                rec_code,
  output logic [F+MB+2:0]      rec_num,
  output logic [MB+2:0]        rec_den
);

  localparam int DW    = MB + 1;
  localparam int OPA_W = MAG_W + 2;
  localparam int PW    = OPA_W + DW;
  localparam int SCW   = (OPA_W > F + 1) ? OPA_W : F + 1;
  localparam int SQIW  = ((MAG_W + MB > F + 1) ? MAG_W + MB : F + 1) + 1;
  localparam int AW    = ((PW + 1 > F + 4) ? PW + 1 : F + 4) + 1;
  localparam int YW    = MB + 1;
  localparam int NW    = F + MB + 3;
  localparam int DDW   = MB + 3;

  localparam logic [SCW-1:0] ONE_S = SCW'(1) << F;
  localparam logic [YW-1:0]  Y_CAP = YW'(3) << (MB - 1);
  localparam logic [YW:0]    RC    = (YW + 1)'((2 ** (YW + 1) + 2) / 3);

  logic f_adv;

  // stage 1
  logic                 s1_vld;
  logic                 s1_neg;
  logic [MAG_W-1:0]     s1_mag;
  logic [WID_W-1:0]     s1_m;
  logic [GSEL_W-1:0]    s1_g;
  logic [MAG_W-1:0]     mag_c;
  logic [WID_W-1:0]     m_c;
  logic [GSEL_W-1:0]    g_c;

  // stage 2
  logic                 s2_vld;
  logic                 s2_neg;
  logic [WID_W-1:0]     s2_m;
  logic [GSEL_W-1:0]    s2_g;
  logic [PW-1:0]        s2_prod;
  logic [MB-1:0]        s2_sq;
  logic                 s2_small;
  logic [MB-1:0]        lvl1;
  logic [DW-1:0]        d1;
  logic [SCW-1:0]       scaled;
  logic [OPA_W-1:0]     diff;
  logic [OPA_W-1:0]     opa;
  logic [DW-1:0]        opb;
  logic [SQIW-1:0]      sq_full;
  logic [MB-1:0]        sh1;

  // stage 3
  logic                 s3_vld;
  logic                 s3_neg;
  logic [WID_W-1:0]     s3_m;
  logic [GSEL_W-1:0]    s3_g;
  logic [MB-1:0]        s3_sq;
  logic                 s3_small;
  logic [MB-1:0]        s3_qk;
  logic [YW-1:0]        s3_y;
  logic [AW-1:0]        qk_full;
  logic [AW-1:0]        y_full;
  logic [MB-1:0]        qcap;

  // stage 4
  logic                 s4_vld;
  logic                 s4_neg;
  logic [WID_W-1:0]     s4_m;
  logic [GSEL_W-1:0]    s4_g;
  logic [MB-1:0]        s4_sq;
  logic                 s4_small;
  logic [MB-1:0]        s4_qk;
  logic [2*YW:0]        s4_k3p;

  // stage 5
  logic                 s5_vld;
  code_t                s5_code;
  logic [NW-1:0]        s5_num;
  logic [DDW-1:0]       s5_den;
  code_t                code_c;
  logic [NW-1:0]        num_c;
  logic [DDW-1:0]       den_c;
  logic [YW-1:0]        k3;
  logic [MB-1:0]        cap3;
  logic [MB-1:0]        k3c;
  logic [MB-1:0]        kk;
  logic [WID_W-1:0]     sb;
  logic [WID_W-1:0]     lb;
  logic [MB-1:0]        mask_m;
  logic [MB-1:0]        mask_sb;
  logic [MB-1:0]        mask_lb;
  logic [MB-1:0]        lvl5;
  logic [DW-1:0]        d5;
  logic [MB-1:0]        pcode;
  logic [MB-1:0]        xcode;
  logic [DDW-1:0]       tsum;

  assign f_adv      = !s5_vld || !rec_full;
  assign item_ready = f_adv;
  assign rec_valid  = s5_vld;
  assign rec_code   = s5_code;
  assign rec_num    = s5_num;
  assign rec_den    = s5_den;

  // stage 1: magnitude and clamped controls
  always_comb begin
    mag_c = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
    if (mantissa_width < MIN_MANT) begin
      m_c = MIN_MANT;
    end else if (mantissa_width > WID_W'(MB)) begin
      m_c = WID_W'(MB);
    end else begin
      m_c = mantissa_width;
    end
    g_c = (gain_select == GAIN_RSVD) ? GAIN_X1 : gain_select;
  end

  // stage 2: one shared multiplier, small quantizer trial
  always_comb begin
    lvl1   = (MB'(1) << s1_m) - MB'(1);
    d1     = (s1_g == GAIN_X2) ? ((DW'(1) << (s1_m - 5'd1)) - DW'(1))
                               : ((DW'(1) << (s1_m + 5'd1)) - DW'(2));
    scaled = SCW'(s1_mag) << s1_g;
    diff   = (scaled > ONE_S) ? OPA_W'(scaled - ONE_S) : '0;
    opa    = (s1_g == GAIN_X1) ? OPA_W'(s1_mag) : diff;
    opb    = (s1_g == GAIN_X1) ? DW'(lvl1) : d1;
    sq_full = ((SQIW'(s1_mag) << (s1_m - 5'd1)) + (SQIW'(1) << (F - 1))) >> F;
    sh1    = MB'(1) << (s1_m - WID_W'(s1_g) - 5'd1);
  end

  // stage 3: rounding shifts and clamps
  always_comb begin
    qk_full = (AW'(s2_prod) + (AW'(1) << F)) >> (F + 1);
    qcap    = (s2_g == GAIN_X1) ? ((MB'(1) << (s2_m - 5'd1)) - MB'(1))
                                : ((MB'(1) << (s2_m - 5'd2)) - MB'(1));
    y_full  = ((AW'(s2_prod) << 1) + (AW'(3) << (F + 2))) >> (F + 3);
  end

  // stage 5: codes and division operands
  always_comb begin
    k3      = YW'(s4_k3p >> (YW + 1));
    cap3    = (MB'(1) << (s4_m - 5'd1)) - MB'(1);
    k3c     = (k3 > YW'(cap3)) ? cap3 : k3[MB-1:0];
    kk      = (s4_g == GAIN_X4) ? k3c : s4_qk;
    sb      = s4_m - WID_W'(s4_g);
    lb      = (s4_g == GAIN_X2) ? (s4_m - 5'd1) : s4_m;
    mask_m  = (MB'(1) << s4_m) - MB'(1);
    mask_sb = (MB'(1) << sb) - MB'(1);
    mask_lb = (MB'(1) << lb) - MB'(1);
    lvl5    = (MB'(1) << s4_m) - MB'(1);
    d5      = (s4_g == GAIN_X2) ? ((DW'(1) << (s4_m - 5'd1)) - DW'(1))
                                : ((DW'(1) << (s4_m + 5'd1)) - DW'(2));
    tsum    = '0;
    pcode   = '0;
    xcode   = '0;
    code_c  = '0;
    code_c.neg = s4_neg;
    num_c   = '0;
    den_c   = '0;
    case (s4_g)
      GAIN_X2, GAIN_X4: begin
        code_c.codeword_width = sb;
        if (s4_small) begin
          pcode = (s4_neg ? (MB'(0) - s4_sq) : s4_sq) & mask_sb;
          num_c = NW'(s4_sq) << F;
          den_c = DDW'(1) << (s4_m - 5'd1);
        end else begin
          pcode = MB'(1) << (sb - 5'd1);
          xcode = (s4_neg ? ~kk : kk) & mask_lb;
          code_c.escape_used  = 1'b1;
          code_c.escape_width = lb;
          if (s4_g == GAIN_X2) begin
            tsum  = DDW'(d5) + (DDW'(kk) << 1);
            den_c = DDW'(d5) << 1;
          end else begin
            tsum  = DDW'(d5) + (DDW'(kk) << 3) + (DDW'(kk) << 2);
            den_c = DDW'(d5) << 2;
          end
          num_c = NW'(tsum) << F;
        end
      end
      default: begin
        pcode = (s4_neg ? (MB'(0) - s4_qk) : s4_qk) & mask_m;
        code_c.codeword_width = s4_m;
        num_c = NW'(s4_qk) << (F + 1);
        den_c = DDW'(lvl5);
      end
    endcase
    code_c.codeword    = CODE_W'(pcode);
    code_c.escape_code = CODE_W'(xcode);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
    end else if (f_adv) begin
      s1_vld <= item_valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv) begin
      s1_neg   <= sample[SAMPLE_W-1];
      s1_mag   <= mag_c;
      s1_m     <= m_c;
      s1_g     <= g_c;

      s2_neg   <= s1_neg;
      s2_m     <= s1_m;
      s2_g     <= s1_g;
      s2_prod  <= opa * opb;
      s2_sq    <= sq_full[MB-1:0];
      s2_small <= (sq_full < SQIW'(sh1));

      s3_neg   <= s2_neg;
      s3_m     <= s2_m;
      s3_g     <= s2_g;
      s3_sq    <= s2_sq;
      s3_small <= s2_small;
      s3_qk    <= (qk_full > AW'(qcap)) ? qcap : qk_full[MB-1:0];
      s3_y     <= (y_full > AW'(Y_CAP)) ? Y_CAP : y_full[YW-1:0];

      s4_neg   <= s3_neg;
      s4_m     <= s3_m;
      s4_g     <= s3_g;
      s4_sq    <= s3_sq;
      s4_small <= s3_small;
      s4_qk    <= s3_qk;
      s4_k3p   <= s3_y * RC;

      s5_code  <= code_c;
      s5_num   <= num_c;
      s5_den   <= den_c;
    end
  end

endmodule

// ===== rtl/ahtgaq_back.sv =====
// ----------------------------------------------------------------------------
// ahtgaq_back
// Pipelined restoring divider for the reconstruction, saturation and the
// result register.
// ----------------------------------------------------------------------------
module ahtgaq_back import ahtgaq_pkg::*; #(
  parameter int MB = 16,
  parameter int F  = 23
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_valid,
  output logic                 rec_pop,
  input  code_t                rec_code,
  input  logic [F+MB+2:0]      rec_num,
  input  logic [MB+2:0]        rec_den,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [CODE_W-1:0]    codeword,
  output logic [WID_W-1:0]     codeword_width,
  output logic                 escape_used,
  output logic [CODE_W-1:0]    escape_code,
  output logic [WID_W-1:0]     escape_width,
  output logic [SAMPLE_W-1:0]  reconstruction
);

  localparam int DDW = MB + 3;
  localparam int XW  = F + MB + 5;
  localparam int QB  = F + 2;
  localparam int RW  = DDW + 1;
  localparam int EW  = (QB > 25) ? QB : 25;

  localparam logic [EW-1:0] ONE_E   = EW'(1) << F;
  localparam logic [EW-1:0] POS_CAP = (F < 23) ? (ONE_E - EW'(1)) : EW'(24'h7FFFFF);
  localparam logic [EW-1:0] NEG_CAP = (F < 23) ? ONE_E : EW'(24'h800000);

  logic adv;

  logic           l_vld;
  code_t          l_code;
  logic [XW-1:0]  l_x;
  logic [RW-1:0]  l_den2;

  logic           dv_vld  [QB];
  code_t          dv_code [QB];
  logic [RW-1:0]  dv_rem  [QB];
  logic [QB-1:0]  dv_xl   [QB];
  logic [QB-1:0]  dv_q    [QB];
  logic [RW-1:0]  dv_den2 [QB];

  logic [RW-1:0]  nx_rem  [QB];
  logic [QB-1:0]  nx_xl   [QB];
  logic [QB-1:0]  nx_q    [QB];

  logic [RW-1:0]  src_rem;
  logic [QB-1:0]  src_xl;
  logic [QB-1:0]  src_q;
  logic [RW-1:0]  src_den;
  logic [RW:0]    trial;
  logic           ge;

  logic [EW-1:0]       rm_e;
  logic [EW-1:0]       pos_m;
  logic [EW-1:0]       neg_m;
  logic [SAMPLE_W-1:0] recon_c;
  code_t               last_code;

  assign adv     = !result_valid || result_ready;
  assign rec_pop = adv && rec_valid;

  // one quotient bit per stage
  always_comb begin
    src_rem = '0;
    src_xl  = '0;
    src_q   = '0;
    src_den = '0;
    trial   = '0;
    ge      = 1'b0;
    for (int j = 0; j < QB; j++) begin
      if (j == 0) begin
        src_rem = RW'(l_x[XW-1:QB]);
        src_xl  = l_x[QB-1:0];
        src_q   = '0;
        src_den = l_den2;
      end else begin
        src_rem = dv_rem[j-1];
        src_xl  = dv_xl[j-1];
        src_q   = dv_q[j-1];
        src_den = dv_den2[j-1];
      end
      trial     = {src_rem, src_xl[QB-1]};
      ge        = (trial >= {1'b0, src_den});
      nx_rem[j] = ge ? RW'(trial - {1'b0, src_den}) : RW'(trial);
      nx_xl[j]  = src_xl << 1;
      nx_q[j]   = {src_q[QB-2:0], ge};
    end
  end

  always_comb begin
    last_code = dv_code[QB-1];
    rm_e      = EW'(dv_q[QB-1]);
    pos_m     = (rm_e > POS_CAP) ? POS_CAP : rm_e;
    neg_m     = (rm_e > NEG_CAP) ? NEG_CAP : rm_e;
    recon_c   = last_code.neg ? (SAMPLE_W'(0) - SAMPLE_W'(neg_m)) : SAMPLE_W'(pos_m);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l_vld        <= 1'b0;
      result_valid <= 1'b0;
      for (int j = 0; j < QB; j++) begin
        dv_vld[j] <= 1'b0;
      end
    end else if (adv) begin
      l_vld <= rec_valid;
      for (int j = 0; j < QB; j++) begin
        dv_vld[j] <= (j == 0) ? l_vld : dv_vld[j-1];
      end
      result_valid <= dv_vld[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_code <= rec_code;
      l_x    <= (XW'(rec_num) << 1) + XW'(rec_den);
      l_den2 <= RW'(rec_den) << 1;
      for (int j = 0; j < QB; j++) begin
        dv_code[j] <= (j == 0) ? l_code : dv_code[j-1];
        dv_den2[j] <= (j == 0) ? l_den2 : dv_den2[j-1];
        dv_rem[j]  <= nx_rem[j];
        dv_xl[j]   <= nx_xl[j];
        dv_q[j]    <= nx_q[j];
      end
      codeword       <= last_code.codeword;
      codeword_width <= last_code.codeword_width;
      escape_used    <= last_code.escape_used;
      escape_code    <= last_code.escape_code;
      escape_width   <= last_code.escape_width;
      reconstruction <= recon_c;
    end
  end

  a_no_escape_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !escape_used) |-> (escape_width == '0 && escape_code == '0))
    else $error("escape fields set without escape");

endmodule

// ===== rtl/aht_gain_adaptive_quantizer.sv =====
// ----------------------------------------------------------------------------
// aht_gain_adaptive_quantizer
// Gain-adaptive mantissa quantizer for transform coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: sample, mantissa_width, gain_select with item_valid and
//   item_ready; one transaction per coefficient.
//   result channel: codeword, widths, escape word and reconstruction with
//   result_valid and result_ready; one transaction per coefficient, in order.
//   Throughput: one coefficient per cycle unless the receiver stalls.
//   The front is a five-stage pipeline, a four-entry queue follows, then
//   the back: an operand stage, a restoring divider of SAMPLE_FRACTION_BITS+2
//   stages, one quotient bit each, and the result register.
//   Reset empties every stage and the queue; no result is valid after it.
//   When the receiver stalls, the back holds; the front takes items until
//   the queue is full and its last stage holds one, then drops item_ready.
// ----------------------------------------------------------------------------
module aht_gain_adaptive_quantizer import ahtgaq_pkg::*; #(
  parameter int MAX_MANTISSA_BITS    = 16,
  parameter int SAMPLE_FRACTION_BITS = 23
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic [WID_W-1:0]     mantissa_width,
  input  logic [GSEL_W-1:0]    gain_select,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [CODE_W-1:0]    codeword,
  output logic [WID_W-1:0]     codeword_width,
  output logic                 escape_used,
  output logic [CODE_W-1:0]    escape_code,
  output logic [WID_W-1:0]     escape_width,
  output logic [SAMPLE_W-1:0]  reconstruction
);

  localparam int MB    = MAX_MANTISSA_BITS;
  localparam int F     = SAMPLE_FRACTION_BITS;
  localparam int NW    = F + MB + 3;
  localparam int DDW   = MB + 3;
  localparam int REC_W = CODE_T_W + NW + DDW;

  logic             f_valid;
  code_t            f_code;
  logic [NW-1:0]    f_num;
  logic [DDW-1:0]   f_den;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [REC_W-1:0] q_data;
  code_t            b_code;
  logic [NW-1:0]    b_num;
  logic [DDW-1:0]   b_den;

  ahtgaq_front #(
    .MB (MB),
    .F  (F)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .sample         (sample),
    .mantissa_width (mantissa_width),
    .gain_select    (gain_select),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .rec_valid      (f_valid),
    .rec_full       (q_full),
    .rec_code       (f_code),
    .rec_num        (f_num),
    .rec_den        (f_den)
  );

  ahtgaq_fifo #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data ({f_code, f_num, f_den}),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_data)
  );

  assign {b_code, b_num, b_den} = q_data;

  ahtgaq_back #(
    .MB (MB),
    .F  (F)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .rec_valid      (!q_empty),
    .rec_pop        (q_pop),
    .rec_code       (b_code),
    .rec_num        (b_num),
    .rec_den        (b_den),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .codeword       (codeword),
    .codeword_width (codeword_width),
    .escape_used    (escape_used),
    .escape_code    (escape_code),
    .escape_width   (escape_width),
    .reconstruction (reconstruction)
  );

endmodule
